// File: sv/tsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants for the triangle sweep generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int DAC_BITS = 12;
    localparam int CODE_W   = 12;
    localparam int CMP_W    = (DAC_BITS > CODE_W) ? DAC_BITS : CODE_W;
    localparam int DIV_W    = 16;
    localparam int CYC_W    = 8;
    localparam int HALF_W   = CYC_W + 1;
    localparam int ADC_W    = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    localparam logic [HALF_W-1:0] HALF_MAX = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_LOWER_CODE   = 3'd0,
        REG_UPPER_CODE   = 3'd1,
        REG_START_CODE   = 3'd2,
        REG_START_RISING = 3'd3,
        REG_TICK_DIVIDER = 3'd4,
        REG_SWEEP_CYCLES = 3'd5
    } reg_idx_t;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_START = 1'b1
    } func_t;

endpackage

// File: sv/triangle_sweep_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_sweep_generator
// Triangle sweep of a DAC code for cyclic voltammetry, paired with ADC samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func and adc_sample. func START
//   loads the sweep state from the registers; func TICK is one tick of the DAC
//   update clock. Every input transfer gives exactly one result transfer on the
//   output channel (out_valid/out_ready): sample_valid, dac_code, adc_value,
//   finished.
//   Path: an input transfer fills the input register, the sweep step then
//   writes the result register, and the result transfers on the output channel.
//   Throughput: one item per cycle while out_ready is high; the sweep step is
//   a compare and an increment or decrement between those two registers.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while no item is in flight.
//   Reset: registers take their defaults, the sweep reports finished until a
//   START item, and both pipeline stages are empty.
//   Stall: while out_ready is low the result holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module triangle_sweep_generator
    import tsg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [ADC_W-1:0]    adc_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                sample_valid,
    output logic [CODE_W-1:0]   dac_code,
    output logic [ADC_W-1:0]    adc_value,
    output logic                finished
);

    // configuration
    logic [CODE_W-1:0] lower_code_reg, upper_code_reg, start_code_reg;
    logic              start_rising_reg;
    logic [DIV_W-1:0]  tick_divider_reg;
    logic [CYC_W-1:0]  sweep_cycles_reg;

    // sweep state
    logic [DAC_BITS-1:0] level_reg, level_next;
    logic                going_up_reg, going_up_next;
    logic [HALF_W-1:0]   half_reg, half_next;
    logic [DIV_W-1:0]    skip_reg, skip_next;
    logic                done_reg, done_next;

    // pipeline
    logic              in_full_reg;
    logic              func_reg;
    logic [ADC_W-1:0]  adc_reg;
    logic              out_valid_reg;
    logic              sample_valid_reg, sample_valid_next;
    logic [CODE_W-1:0] dac_code_reg, dac_code_next;
    logic [ADC_W-1:0]  adc_value_reg, adc_value_next;

    logic advance;
    logic take;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_full_reg || advance;
    assign take     = in_full_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_code_reg   <= '0;
            upper_code_reg   <= '1;
            start_code_reg   <= '0;
            start_rising_reg <= 1'b1;
            tick_divider_reg <= '0;
            sweep_cycles_reg <= CYC_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOWER_CODE:   lower_code_reg   <= cfg_data[CODE_W-1:0];
                REG_UPPER_CODE:   upper_code_reg   <= cfg_data[CODE_W-1:0];
                REG_START_CODE:   start_code_reg   <= cfg_data[CODE_W-1:0];
                REG_START_RISING: start_rising_reg <= cfg_data[0];
                REG_TICK_DIVIDER: tick_divider_reg <= cfg_data[DIV_W-1:0];
                REG_SWEEP_CYCLES: sweep_cycles_reg <= cfg_data[CYC_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic [DAC_BITS-1:0] step;
        logic [1:0]          inc;
        logic [HALF_W:0]     sum;
        logic                done_now;

        level_next        = level_reg;
        going_up_next     = going_up_reg;
        half_next         = half_reg;
        skip_next         = skip_reg;
        done_next         = done_reg;
        sample_valid_next = 1'b0;
        dac_code_next     = '0;
        adc_value_next    = '0;
        step              = '0;
        inc               = '0;
        sum               = '0;
        done_now          = 1'b0;

        if (func_reg == FUNC_START)
        begin
            level_next    = DAC_BITS'(start_code_reg);
            going_up_next = start_rising_reg;
            half_next     = '0;
            skip_next     = '0;
            done_next     = (sweep_cycles_reg == '0);
        end
        else
        begin
            done_now  = done_reg || (half_reg[HALF_W-1:1] >= sweep_cycles_reg);
            done_next = done_now;
            if (!done_now)
            begin
                if (skip_reg == tick_divider_reg)
                begin
                    sample_valid_next = 1'b1;
                    dac_code_next     = CODE_W'(level_reg);
                    adc_value_next    = adc_reg;
                    skip_next         = '0;
                    if (going_up_reg)
                    begin
                        step = level_reg + 1'b1;
                        if (CMP_W'(step) == CMP_W'(start_code_reg))
                        begin
                            inc = 2'd1;
                            if (CMP_W'(step) == CMP_W'(upper_code_reg))
                            begin
                                going_up_next = 1'b0;
                                inc           = 2'd2;
                            end
                        end
                        else if (CMP_W'(step) >= CMP_W'(upper_code_reg))
                        begin
                            going_up_next = 1'b0;
                        end
                    end
                    else
                    begin
                        step = level_reg - 1'b1;
                        if (level_reg == '0 || CMP_W'(step) >= CMP_W'(upper_code_reg))
                        begin
                            step = '0;
                        end
                        if (CMP_W'(step) == CMP_W'(start_code_reg))
                        begin
                            inc = 2'd1;
                            if (CMP_W'(step) == CMP_W'(lower_code_reg))
                            begin
                                going_up_next = 1'b1;
                                inc           = 2'd2;
                            end
                        end
                        else if (CMP_W'(step) <= CMP_W'(lower_code_reg))
                        begin
                            going_up_next = 1'b1;
                        end
                    end
                    level_next = step;
                    sum        = {1'b0, half_reg} + (HALF_W+1)'(inc);
                    half_next  = sum[HALF_W] ? HALF_MAX : sum[HALF_W-1:0];
                    done_next  = (half_next[HALF_W-1:1] >= sweep_cycles_reg);
                end
                else
                begin
                    skip_next = skip_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            going_up_reg  <= 1'b1;
            half_reg      <= '0;
            skip_reg      <= '0;
            done_reg      <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_full_reg;
            end
            if (take)
            begin
                level_reg    <= level_next;
                going_up_reg <= going_up_next;
                half_reg     <= half_next;
                skip_reg     <= skip_next;
                done_reg     <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            adc_reg  <= adc_sample;
        end
        if (take)
        begin
            sample_valid_reg <= sample_valid_next;
            dac_code_reg     <= dac_code_next;
            adc_value_reg    <= adc_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_valid = sample_valid_reg;
    assign dac_code     = dac_code_reg;
    assign adc_value    = adc_value_reg;
    assign finished     = done_reg;

endmodule

// File: sv/tsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks for the triangle sweep generator, bound to the top level.
// ----------------------------------------------------------------------------
module tsg_checker
    import tsg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              sample_valid,
    input logic [CODE_W-1:0] dac_code,
    input logic [ADC_W-1:0]  adc_value,
    input logic              finished
);

    logic [1:0] inflight_reg, inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // at most two items between the input and output transfers
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two items in flight");

    // a result only for an item that was taken
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result without a pending item");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sample_valid) |-> (dac_code == '0 && adc_value == '0))
        else $error("nonzero pair without a sample");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(sample_valid) && $stable(dac_code)
             && $stable(adc_value) && $stable(finished)))
        else $error("result changed while stalled");

endmodule

bind triangle_sweep_generator tsg_checker u_tsg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_valid (sample_valid),
    .dac_code     (dac_code),
    .adc_value    (adc_value),
    .finished     (finished)
);
